// ----- rtl/fpfc_pkg.sv -----
// shared types and constants of the frame-buffer pixel format converter
package fpfc_pkg;

  // table sizes
  localparam int unsigned INDEX_TABLE_DEPTH_DEF = 65536;
  localparam int unsigned PALETTE_DEPTH_DEF     = 256;

  // configuration port address width (eight 32-bit registers)
  localparam int unsigned APB_AW = 5;

  // input commands
  typedef enum logic [1:0] {
    CMD_CONVERT  = 2'd0,
    CMD_TABLE_WR = 2'd1,
    CMD_PAL_WR   = 2'd2,
    CMD_IGNORE   = 2'd3
  } cmd_t;

  // source pixel formats
  typedef enum logic [1:0] {
    SRC_IDX8     = 2'd0,
    SRC_RGB555   = 2'd1,
    SRC_RGB565   = 2'd2,
    SRC_XRGB8888 = 2'd3
  } src_fmt_t;

  // destination sizes (code 3 behaves as four bytes)
  localparam logic [1:0] DS_ONE = 2'd0;
  localparam logic [1:0] DS_TWO = 2'd1;

  // register layouts that make a 16-bit source pass through
  localparam logic [4:0] PASS555_RED_SHIFT = 5'd10;
  localparam logic [4:0] PASS565_RED_SHIFT = 5'd11;
  localparam logic [3:0] PASS_RED_BITS     = 4'd5;

  // register reset values
  localparam src_fmt_t   RST_SOURCE_FORMAT = SRC_RGB565;
  localparam logic [1:0] RST_DEST_SIZE     = DS_TWO;
  localparam logic [4:0] RST_RED_SHIFT     = 5'd11;
  localparam logic [4:0] RST_GREEN_SHIFT   = 5'd5;
  localparam logic [4:0] RST_BLUE_SHIFT    = 5'd0;
  localparam logic [3:0] RST_RED_BITS      = 4'd5;
  localparam logic [3:0] RST_GREEN_BITS    = 4'd6;
  localparam logic [3:0] RST_BLUE_BITS     = 4'd5;

  // configuration register set
  typedef struct packed {
    src_fmt_t   source_format;
    logic [1:0] dest_size;
    logic [4:0] red_shift;
    logic [4:0] green_shift;
    logic [4:0] blue_shift;
    logic [3:0] red_bits;
    logic [3:0] green_bits;
    logic [3:0] blue_bits;
  } cfg_t;

  // conversion path chosen for a pixel
  typedef enum logic [3:0] {
    MODE_PASS8,
    MODE_PASS16,
    MODE_PASS32,
    MODE_TABLE,
    MODE_PAL_FIELDS,
    MODE_PAL_WIDE,
    MODE_555_TO_565,
    MODE_555_WIDE,
    MODE_565_TO_555,
    MODE_565_WIDE,
    MODE_X_FIELDS
  } mode_t;

  // payload from the memory stage to the format stages
  typedef struct packed {
    mode_t       mode;
    logic [31:0] pixel;
    logic [7:0]  table_data;
    logic [23:0] pal_data;
    logic        frame_last;
  } mem_out_t;

endpackage

// ----- rtl/fpfc_if.sv -----
// valid/ready channel interfaces for pixel input and pixel output

interface fpfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] pixel_in;
  logic [15:0] table_index;
  logic [7:0]  table_value;
  logic [7:0]  pal_red;
  logic [7:0]  pal_green;
  logic [7:0]  pal_blue;
  logic        end_of_frame;

  modport source (
    output valid, command, pixel_in, table_index, table_value,
           pal_red, pal_green, pal_blue, end_of_frame,
    input  ready
  );
  modport sink (
    input  valid, command, pixel_in, table_index, table_value,
           pal_red, pal_green, pal_blue, end_of_frame,
    output ready
  );
endinterface

interface fpfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        frame_last;

  modport source (
    output valid, pixel_out, frame_last,
    input  ready
  );
  modport sink (
    input  valid, pixel_out, frame_last,
    output ready
  );
endinterface

// ----- rtl/fpfc_cfg.sv -----
// configuration register file behind the APB-style port
module fpfc_cfg
  import fpfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  typedef enum logic [2:0] {
    REG_SOURCE_FORMAT = 3'd0,
    REG_DEST_SIZE     = 3'd1,
    REG_RED_SHIFT     = 3'd2,
    REG_GREEN_SHIFT   = 3'd3,
    REG_BLUE_SHIFT    = 3'd4,
    REG_RED_BITS      = 3'd5,
    REG_GREEN_BITS    = 3'd6,
    REG_BLUE_BITS     = 3'd7
  } reg_idx_t;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_format <= RST_SOURCE_FORMAT;
      cfg.dest_size     <= RST_DEST_SIZE;
      cfg.red_shift     <= RST_RED_SHIFT;
      cfg.green_shift   <= RST_GREEN_SHIFT;
      cfg.blue_shift    <= RST_BLUE_SHIFT;
      cfg.red_bits      <= RST_RED_BITS;
      cfg.green_bits    <= RST_GREEN_BITS;
      cfg.blue_bits     <= RST_BLUE_BITS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SOURCE_FORMAT: cfg.source_format <= src_fmt_t'(pwdata[1:0]);
        REG_DEST_SIZE:     cfg.dest_size     <= pwdata[1:0];
        REG_RED_SHIFT:     cfg.red_shift     <= pwdata[4:0];
        REG_GREEN_SHIFT:   cfg.green_shift   <= pwdata[4:0];
        REG_BLUE_SHIFT:    cfg.blue_shift    <= pwdata[4:0];
        REG_RED_BITS:      cfg.red_bits      <= pwdata[3:0];
        REG_GREEN_BITS:    cfg.green_bits    <= pwdata[3:0];
        REG_BLUE_BITS:     cfg.blue_bits     <= pwdata[3:0];
      endcase
    end
  end

  // read data
  always_comb begin
    unique case (reg_idx)
      REG_SOURCE_FORMAT: prdata = {30'b0, cfg.source_format};
      REG_DEST_SIZE:     prdata = {30'b0, cfg.dest_size};
      REG_RED_SHIFT:     prdata = {27'b0, cfg.red_shift};
      REG_GREEN_SHIFT:   prdata = {27'b0, cfg.green_shift};
      REG_BLUE_SHIFT:    prdata = {27'b0, cfg.blue_shift};
      REG_RED_BITS:      prdata = {28'b0, cfg.red_bits};
      REG_GREEN_BITS:    prdata = {28'b0, cfg.green_bits};
      REG_BLUE_BITS:     prdata = {28'b0, cfg.blue_bits};
    endcase
  end

endmodule

// ----- rtl/fpfc_mem.sv -----
// decode stage and table/palette memory stage
module fpfc_mem
  import fpfc_pkg::*;
#(
  parameter int unsigned INDEX_TABLE_DEPTH = INDEX_TABLE_DEPTH_DEF,
  parameter int unsigned PALETTE_DEPTH     = PALETTE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  fpfc_in_if.sink  src,
  output logic     m_valid,
  input  logic     m_ready,
  output mem_out_t m_data
);

  localparam int unsigned TAW = $clog2(INDEX_TABLE_DEPTH);
  localparam int unsigned PAW = $clog2(PALETTE_DEPTH);

  // decode signals
  logic        ds_one;
  logic        ds_two;
  mode_t       mode;
  logic [15:0] rd_addr;
  logic [16:0] t_wide;
  logic [16:0] t_red;
  logic [TAW-1:0] t_idx;
  logic [PAW-1:0] p_idx;

  // stage 1 registers
  logic           v1;
  cmd_t           s1_cmd;
  mode_t          s1_mode;
  logic [TAW-1:0] s1_tidx;
  logic [PAW-1:0] s1_pidx;
  logic [31:0]    s1_pix;
  logic [7:0]     s1_tval;
  logic [23:0]    s1_pal;
  logic           s1_eof;

  // stage 2 registers and memories
  logic        v2;
  mode_t       s2_mode;
  logic [31:0] s2_pix;
  logic        s2_eof;
  logic [7:0]  tbl_q;
  logic [23:0] pal_q;
  logic [7:0]  tbl_mem [INDEX_TABLE_DEPTH];
  logic [23:0] pal_mem [PALETTE_DEPTH];

  logic rdy1;
  logic rdy2;

  assign rdy2      = !v2 || m_ready;
  assign rdy1      = !v1 || rdy2;
  assign src.ready = rdy1;

  // conversion path from the configured formats
  always_comb begin
    ds_one = (cfg.dest_size == DS_ONE);
    ds_two = (cfg.dest_size == DS_TWO);
    unique case (cfg.source_format)
      SRC_IDX8: begin
        mode = ds_one ? MODE_PASS8 : (ds_two ? MODE_PAL_FIELDS : MODE_PAL_WIDE);
      end
      SRC_RGB555: begin
        if (ds_one) begin
          mode = MODE_TABLE;
        end else if (ds_two) begin
          mode = (cfg.red_shift == PASS555_RED_SHIFT && cfg.red_bits == PASS_RED_BITS) ?
                 MODE_PASS16 : MODE_555_TO_565;
        end else begin
          mode = MODE_555_WIDE;
        end
      end
      SRC_RGB565: begin
        if (ds_one) begin
          mode = MODE_TABLE;
        end else if (ds_two) begin
          mode = (cfg.red_shift == PASS565_RED_SHIFT && cfg.red_bits == PASS_RED_BITS) ?
                 MODE_PASS16 : MODE_565_TO_555;
        end else begin
          mode = MODE_565_WIDE;
        end
      end
      SRC_XRGB8888: begin
        mode = ds_one ? MODE_TABLE : (ds_two ? MODE_X_FIELDS : MODE_PASS32);
      end
    endcase
  end

  // table address: 565 reduction for 32-bit sources, less the table depth once if at or above it
  always_comb begin
    if (cfg.source_format == SRC_XRGB8888) begin
      rd_addr = {src.pixel_in[23:19], src.pixel_in[15:10], src.pixel_in[7:3]};
    end else begin
      rd_addr = src.pixel_in[15:0];
    end
    t_wide = (cmd_t'(src.command) == CMD_TABLE_WR) ? {1'b0, src.table_index}
                                                   : {1'b0, rd_addr};
    t_red  = (t_wide >= 17'(INDEX_TABLE_DEPTH)) ? t_wide - 17'(INDEX_TABLE_DEPTH) : t_wide;
    t_idx  = t_red[TAW-1:0];
    p_idx  = (cmd_t'(src.command) == CMD_PAL_WR) ? src.table_index[PAW-1:0]
                                                 : src.pixel_in[PAW-1:0];
  end

  // stage 1: decoded transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && src.valid) begin
      s1_cmd  <= cmd_t'(src.command);
      s1_mode <= mode;
      s1_tidx <= t_idx;
      s1_pidx <= p_idx;
      s1_pix  <= src.pixel_in;
      s1_tval <= src.table_value;
      s1_pal  <= {src.pal_red, src.pal_green, src.pal_blue};
      s1_eof  <= src.end_of_frame;
    end
  end

  // stage 2: only convert transactions go on
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1 && (s1_cmd == CMD_CONVERT);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_mode <= s1_mode;
      s2_pix  <= s1_pix;
      s2_eof  <= s1_eof;
    end
  end

  // index table
  always_ff @(posedge clk) begin
    if (rdy2 && v1 && s1_cmd == CMD_TABLE_WR) begin
      tbl_mem[s1_tidx] <= s1_tval;
    end
    if (rdy2) begin
      tbl_q <= tbl_mem[s1_tidx];
    end
  end

  // color palette
  always_ff @(posedge clk) begin
    if (rdy2 && v1 && s1_cmd == CMD_PAL_WR) begin
      pal_mem[s1_pidx] <= s1_pal;
    end
    if (rdy2) begin
      pal_q <= pal_mem[s1_pidx];
    end
  end

  assign m_valid = v2;
  assign m_data  = '{mode: s2_mode, pixel: s2_pix, table_data: tbl_q,
                     pal_data: pal_q, frame_last: s2_eof};

  // a stalled decode stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(s1_pix) && $stable(s1_mode) && $stable(s1_cmd))
    else $error("decode stage changed while stalled");

  // table and palette writes never turn into results
  a_wr_dropped: assert property (@(posedge clk) disable iff (rst)
    v1 && rdy2 && s1_cmd != CMD_CONVERT |=> !v2)
    else $error("write transaction reached the format stages");

  // an accepted transaction lands in the decode stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    src.valid && src.ready |=> v1)
    else $error("accepted transaction lost");

endmodule

// ----- rtl/fpfc_fmt.sv -----
// channel extraction stage and field packing output stage
module fpfc_fmt
  import fpfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      m_valid,
  output logic      m_ready,
  input  mem_out_t  m_data,
  fpfc_out_if.source dst
);

  // channel values and their destination positions
  logic        direct;
  logic [31:0] dval;
  logic [7:0]  cr, cg, cb;
  logic [5:0]  sr, sg, sb;
  logic        narrow;
  logic [3:0]  rb, gb, bb;
  logic [3:0]  r_drop, g_drop, b_drop;
  logic [7:0]  fr, fg, fb;
  logic [15:0] h;

  // stage 3 registers
  logic        v3;
  logic        s3_direct;
  logic [31:0] s3_dval;
  logic [7:0]  s3_cr, s3_cg, s3_cb;
  logic [5:0]  s3_sr, s3_sg, s3_sb;
  logic        s3_narrow;
  logic        s3_eof;

  // stage 4 (output) registers
  logic        v4;
  logic [31:0] pixel;
  logic        eof;
  logic [31:0] packed_px;

  logic rdy3;
  logic rdy4;

  assign rdy4    = !v4 || dst.ready;
  assign rdy3    = !v3 || rdy4;
  assign m_ready = rdy3;

  function automatic logic [3:0] clamp_bits(input logic [3:0] b);
    logic [3:0] c;
    if (b == 4'd0) begin
      c = 4'd1;
    end else if (b > 4'd8) begin
      c = 4'd8;
    end else begin
      c = b;
    end
    return c;
  endfunction

  // field reduction amounts for configurable layouts
  always_comb begin
    rb     = clamp_bits(cfg.red_bits);
    gb     = clamp_bits(cfg.green_bits);
    bb     = clamp_bits(cfg.blue_bits);
    r_drop = 4'd8 - rb;
    g_drop = 4'd8 - gb;
    b_drop = 4'd8 - bb;
    h      = m_data.pixel[15:0];
    if (m_data.mode == MODE_PAL_FIELDS) begin
      fr = m_data.pal_data[23:16];
      fg = m_data.pal_data[15:8];
      fb = m_data.pal_data[7:0];
    end else begin
      fr = m_data.pixel[23:16];
      fg = m_data.pixel[15:8];
      fb = m_data.pixel[7:0];
    end
  end

  // per-path channel selection
  always_comb begin
    direct = 1'b0;
    dval   = '0;
    cr     = '0;
    cg     = '0;
    cb     = '0;
    sr     = '0;
    sg     = '0;
    sb     = '0;
    narrow = 1'b0;
    unique case (m_data.mode)
      MODE_PASS8: begin
        direct = 1'b1;
        dval   = {24'b0, m_data.pixel[7:0]};
      end
      MODE_PASS16: begin
        direct = 1'b1;
        dval   = {16'b0, m_data.pixel[15:0]};
      end
      MODE_PASS32: begin
        direct = 1'b1;
        dval   = m_data.pixel;
      end
      MODE_TABLE: begin
        direct = 1'b1;
        dval   = {24'b0, m_data.table_data};
      end
      MODE_PAL_FIELDS, MODE_X_FIELDS: begin
        cr     = fr >> r_drop[2:0];
        cg     = fg >> g_drop[2:0];
        cb     = fb >> b_drop[2:0];
        sr     = {1'b0, cfg.red_shift};
        sg     = {1'b0, cfg.green_shift};
        sb     = {1'b0, cfg.blue_shift};
        narrow = 1'b1;
      end
      MODE_PAL_WIDE: begin
        cr = {3'b0, m_data.pal_data[23:19]};
        cg = {2'b0, m_data.pal_data[15:10]};
        cb = {3'b0, m_data.pal_data[7:3]};
        sr = {1'b0, cfg.red_shift} + 6'd3;
        sg = {1'b0, cfg.green_shift} + 6'd2;
        sb = {1'b0, cfg.blue_shift} + 6'd3;
      end
      MODE_555_TO_565: begin
        cr     = {3'b0, h[14:10]};
        cg     = {3'b0, h[9:5]};
        cb     = {3'b0, h[4:0]};
        sr     = 6'd11;
        sg     = 6'd6;
        narrow = 1'b1;
      end
      MODE_555_WIDE: begin
        cr = {3'b0, h[14:10]};
        cg = {3'b0, h[9:5]};
        cb = {3'b0, h[4:0]};
        sr = {1'b0, cfg.red_shift} + 6'd3;
        sg = {1'b0, cfg.green_shift} + 6'd3;
        sb = {1'b0, cfg.blue_shift} + 6'd3;
      end
      MODE_565_TO_555: begin
        cr     = {3'b0, h[15:11]};
        cg     = {3'b0, h[10:6]};
        cb     = {3'b0, h[4:0]};
        sr     = 6'd10;
        sg     = 6'd5;
        narrow = 1'b1;
      end
      MODE_565_WIDE: begin
        cr = {3'b0, h[15:11]};
        cg = {2'b0, h[10:5]};
        cb = {3'b0, h[4:0]};
        sr = {1'b0, cfg.red_shift} + 6'd3;
        sg = {1'b0, cfg.green_shift} + 6'd2;
        sb = {1'b0, cfg.blue_shift} + 6'd3;
      end
      default: begin
        direct = 1'b1;
      end
    endcase
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && m_valid) begin
      s3_direct <= direct;
      s3_dval   <= dval;
      s3_cr     <= cr;
      s3_cg     <= cg;
      s3_cb     <= cb;
      s3_sr     <= sr;
      s3_sg     <= sg;
      s3_sb     <= sb;
      s3_narrow <= narrow;
      s3_eof    <= m_data.frame_last;
    end
  end

  // field packing, bits shifted past 31 are dropped
  always_comb begin
    packed_px = ({24'b0, s3_cr} << s3_sr) | ({24'b0, s3_cg} << s3_sg) |
                ({24'b0, s3_cb} << s3_sb);
    if (s3_narrow) begin
      packed_px = {16'b0, packed_px[15:0]};
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      pixel <= s3_direct ? s3_dval : packed_px;
      eof   <= s3_eof;
    end
  end

  assign dst.valid      = v4;
  assign dst.pixel_out  = pixel;
  assign dst.frame_last = eof;

  // a stalled extraction stage keeps its channels
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy4 |=> v3 && $stable(s3_cr) && $stable(s3_sr) && $stable(s3_dval))
    else $error("extraction stage changed while stalled");

  // two-byte layouts never reach the upper half
  a_narrow: assert property (@(posedge clk) disable iff (rst)
    v3 && rdy4 && s3_narrow && !s3_direct |=> pixel[31:16] == 16'h0)
    else $error("two-byte result has upper bits set");

endmodule

// ----- rtl/framebuffer_pixel_format_converter.sv -----
// path: a convert transaction passes decode, memory, extraction and output registers
// throughput: one transaction per cycle unless stalled; stalls back up stage by stage
// table/palette writes and command 3 give no result; the memories sit in one stage
// reset clears all stage valid bits and loads register defaults
// table and palette contents are not cleared and read undefined until written
module framebuffer_pixel_format_converter
  import fpfc_pkg::*;
#(
  parameter int unsigned INDEX_TABLE_DEPTH = INDEX_TABLE_DEPTH_DEF,
  parameter int unsigned PALETTE_DEPTH     = PALETTE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  fpfc_in_if.sink           src,
  fpfc_out_if.source        dst
);

  cfg_t     cfg;
  logic     m_valid;
  logic     m_ready;
  mem_out_t m_data;

  // configuration registers
  fpfc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // decode and memory stages
  fpfc_mem #(
    .INDEX_TABLE_DEPTH (INDEX_TABLE_DEPTH),
    .PALETTE_DEPTH     (PALETTE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .src     (src),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
  );

  // format and output stages
  fpfc_fmt u_fmt (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .dst     (dst)
  );

endmodule
